[rtl/pea_pkg.sv]
// pea_pkg: shared types, event codes and constants of the pointer event accumulator
// used by pea_divider and pointer_event_accumulator_unit; no dependencies
package pea_pkg;

  // coordinate width of the cursor position, 8 to 16
  localparam int CoordW = 16;
  localparam int CntW   = $clog2(CoordW);
  localparam int CoordMaxI = (1 << CoordW) - 1;
  localparam logic [15:0] COORD_MAX = 16'(CoordMaxI);

  // reset register values and derived reset position
  localparam int AbsRangeRstI = 32767;
  localparam int BoundXRstI   = 1919;
  localparam int BoundYRstI   = 1079;
  localparam int PosXRstI = ((BoundXRstI > CoordMaxI) ? CoordMaxI : BoundXRstI) / 2;
  localparam int PosYRstI = ((BoundYRstI > CoordMaxI) ? CoordMaxI : BoundYRstI) / 2;
  localparam logic [15:0] ABS_RANGE_RST = 16'(AbsRangeRstI);
  localparam logic [15:0] BOUND_X_RST   = 16'(BoundXRstI);
  localparam logic [15:0] BOUND_Y_RST   = 16'(BoundYRstI);
  localparam logic [CoordW-1:0] POS_X_RST = CoordW'(PosXRstI);
  localparam logic [CoordW-1:0] POS_Y_RST = CoordW'(PosYRstI);

  // event types
  localparam logic [15:0] EV_SYN = 16'd0;
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;
  localparam logic [15:0] EV_ABS = 16'd3;

  // event codes
  localparam logic [15:0] AXIS_X          = 16'd0;
  localparam logic [15:0] AXIS_Y          = 16'd1;
  localparam logic [15:0] KEY_CODE_LEFT   = 16'h0110;
  localparam logic [15:0] KEY_CODE_RIGHT  = 16'h0111;
  localparam logic [15:0] KEY_CODE_MIDDLE = 16'h0112;
  localparam logic [15:0] SYN_CODE_REPORT = 16'd0;

  // button mask bits
  localparam logic [2:0] BTN_L_BIT = 3'h1;
  localparam logic [2:0] BTN_R_BIT = 3'h2;
  localparam logic [2:0] BTN_M_BIT = 3'h4;

  // configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_ABS_X_RANGE    = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ABS_Y_RANGE    = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_X_BOUND = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_Y_BOUND = 8'd3;

  typedef struct packed {
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic signed [31:0] event_value;
  } pea_in_t;

  typedef struct packed {
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [2:0]  button_mask;
  } pea_out_t;

  // request and response of the shared scaling unit
  typedef struct packed {
    logic              start;
    logic [31:0]       value;
    logic [15:0]       range;
    logic [CoordW-1:0] bound;
  } pea_div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] quotient;
  } pea_div_rsp_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_ITER,
    DV_DONE
  } pea_div_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_DONE
  } pea_state_t;

  // saturate a bound register to the coordinate range
  function automatic logic [CoordW-1:0] eff_bound(input logic [15:0] reg_val);
    logic [CoordW-1:0] res;
    if (reg_val > COORD_MAX) begin
      res = COORD_MAX[CoordW-1:0];
    end else begin
      res = reg_val[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/pea_divider.sv]
// pea_divider: shared scaling unit, clamp and multiply once, then restoring division
// one quotient bit per cycle; depends on pea_pkg
module pea_divider import pea_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pea_div_req_t req,
  output pea_div_rsp_t rsp
);

  localparam int ProdW = 16 + CoordW;

  pea_div_state_t    state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [15:0]       a_r, a_nxt;
  logic [15:0]       range_r, range_nxt;
  logic [CoordW-1:0] bound_r, bound_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [CoordW-1:0] lo_r, lo_nxt;

  logic [ProdW-1:0]  prod;
  logic [16:0]       trial;
  logic [16:0]       diff;
  logic              ge;

  // product of clamped value and bound; the high part stays below the range
  assign prod  = ProdW'(a_r) * ProdW'(bound_r);
  // one restoring step
  assign trial = {rem_r, lo_r[CoordW-1]};
  assign ge    = trial >= {1'b0, range_r};
  assign diff  = trial - {1'b0, range_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    a_r     <= a_nxt;
    range_r <= range_nxt;
    bound_r <= bound_nxt;
    rem_r   <= rem_nxt;
    lo_r    <= lo_nxt;
  end

  // sequencer of the unit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    range_nxt = range_r;
    bound_nxt = bound_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    rsp.done     = 1'b0;
    rsp.quotient = lo_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          if (req.value > {16'd0, req.range}) begin
            a_nxt = req.range;
          end else begin
            a_nxt = req.value[15:0];
          end
          range_nxt = req.range;
          bound_nxt = req.bound;
          state_nxt = DV_MUL;
        end
      end
      DV_MUL: begin
        rem_nxt   = prod[ProdW-1:CoordW];
        lo_nxt    = prod[CoordW-1:0];
        cnt_nxt   = '0;
        state_nxt = DV_ITER;
      end
      DV_ITER: begin
        rem_nxt = ge ? diff[15:0] : trial[15:0];
        lo_nxt  = {lo_r[CoordW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(CoordW - 1)) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

endmodule

[rtl/pointer_event_accumulator_unit.sv]
// pointer_event_accumulator_unit: event decode, cursor state and result register
// depends on pea_pkg and pea_divider
// a key, rel, abs or other event passes the decode and done states into the result register;
// a sync report adds per applied axis a start state, one multiply, 16 iterations
// of the shared divider and a handoff, with the x axis scaled before the y axis.
// one event in flight, a new one is taken only once the block is back in idle; the next is taken while a
// result waits in the output register, a stalled result holds the block in its last step.
// synchronous active-low reset: registers to defaults, cursor at the center of the bounds.
module pointer_event_accumulator_unit import pea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pea_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pea_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_wdata
);

  pea_state_t        state_r, state_nxt;
  pea_in_t           ev_r, ev_nxt;
  logic [15:0]       abs_x_range_r, abs_x_range_nxt;
  logic [15:0]       abs_y_range_r, abs_y_range_nxt;
  logic [15:0]       bound_x_r, bound_x_nxt;
  logic [15:0]       bound_y_r, bound_y_nxt;
  logic [CoordW-1:0] pos_x_r, pos_x_nxt;
  logic [CoordW-1:0] pos_y_r, pos_y_nxt;
  logic [2:0]        buttons_r, buttons_nxt;
  logic [31:0]       pend_x_r, pend_x_nxt;
  logic [31:0]       pend_y_r, pend_y_nxt;
  logic              pend_x_vld_r, pend_x_vld_nxt;
  logic              pend_y_vld_r, pend_y_vld_nxt;
  logic              scale_y_r, scale_y_nxt;
  logic              out_valid_r, out_valid_nxt;
  pea_out_t          out_data_r, out_data_nxt;

  logic [CoordW-1:0] eff_x, eff_y;
  logic [CoordW-1:0] cfg_eff;
  logic [CoordW-1:0] rel_pos, rel_bound;
  logic [33:0]       rel_sum;
  logic [CoordW-1:0] rel_res;
  logic [2:0]        btn_bit;
  pea_div_req_t      div_req;
  pea_div_rsp_t      div_rsp;

  assign eff_x   = eff_bound(bound_x_r);
  assign eff_y   = eff_bound(bound_y_r);
  assign cfg_eff = eff_bound(cfg_wdata);

  // relative move with saturation at zero and the bound
  assign rel_pos   = (ev_r.event_code == AXIS_X) ? pos_x_r : pos_y_r;
  assign rel_bound = (ev_r.event_code == AXIS_X) ? eff_x : eff_y;
  assign rel_sum   = 34'(rel_pos) + {{2{ev_r.event_value[31]}}, ev_r.event_value};
  always_comb begin
    if (rel_sum[33]) begin
      rel_res = '0;
    end else if (rel_sum > 34'(rel_bound)) begin
      rel_res = rel_bound;
    end else begin
      rel_res = rel_sum[CoordW-1:0];
    end
  end

  // button selected by the key code
  always_comb begin
    unique case (ev_r.event_code)
      KEY_CODE_LEFT:   btn_bit = BTN_L_BIT;
      KEY_CODE_RIGHT:  btn_bit = BTN_R_BIT;
      KEY_CODE_MIDDLE: btn_bit = BTN_M_BIT;
      default:         btn_bit = 3'b000;
    endcase
  end

  // shared scaling unit
  pea_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      abs_x_range_r <= ABS_RANGE_RST;
      abs_y_range_r <= ABS_RANGE_RST;
      bound_x_r     <= BOUND_X_RST;
      bound_y_r     <= BOUND_Y_RST;
      pos_x_r       <= POS_X_RST;
      pos_y_r       <= POS_Y_RST;
      buttons_r     <= '0;
      pend_x_r      <= '0;
      pend_y_r      <= '0;
      pend_x_vld_r  <= 1'b0;
      pend_y_vld_r  <= 1'b0;
      scale_y_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      abs_x_range_r <= abs_x_range_nxt;
      abs_y_range_r <= abs_y_range_nxt;
      bound_x_r     <= bound_x_nxt;
      bound_y_r     <= bound_y_nxt;
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      buttons_r     <= buttons_nxt;
      pend_x_r      <= pend_x_nxt;
      pend_y_r      <= pend_y_nxt;
      pend_x_vld_r  <= pend_x_vld_nxt;
      pend_y_vld_r  <= pend_y_vld_nxt;
      scale_y_r     <= scale_y_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    ev_r       <= ev_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer, event decode and configuration writes
  always_comb begin
    state_nxt       = state_r;
    ev_nxt          = ev_r;
    abs_x_range_nxt = abs_x_range_r;
    abs_y_range_nxt = abs_y_range_r;
    bound_x_nxt     = bound_x_r;
    bound_y_nxt     = bound_y_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    buttons_nxt     = buttons_r;
    pend_x_nxt      = pend_x_r;
    pend_y_nxt      = pend_y_r;
    pend_x_vld_nxt  = pend_x_vld_r;
    pend_y_vld_nxt  = pend_y_vld_r;
    scale_y_nxt     = scale_y_r;
    out_data_nxt    = out_data_r;
    in_stall        = (state_r != ST_IDLE);
    div_req.start   = 1'b0;
    div_req.value   = pend_x_r;
    div_req.range   = abs_x_range_r;
    div_req.bound   = eff_x;

    // result register drains on an output transfer
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ev_nxt    = in_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (ev_r.event_type)
          EV_ABS: begin
            if (ev_r.event_code == AXIS_X) begin
              pend_x_nxt     = ev_r.event_value;
              pend_x_vld_nxt = 1'b1;
            end else if (ev_r.event_code == AXIS_Y) begin
              pend_y_nxt     = ev_r.event_value;
              pend_y_vld_nxt = 1'b1;
            end
          end
          EV_REL: begin
            if (ev_r.event_code == AXIS_X) begin
              pos_x_nxt = rel_res;
            end else if (ev_r.event_code == AXIS_Y) begin
              pos_y_nxt = rel_res;
            end
          end
          EV_KEY: begin
            if (ev_r.event_value != 32'sd0) begin
              buttons_nxt = buttons_r | btn_bit;
            end else begin
              buttons_nxt = buttons_r & ~btn_bit;
            end
          end
          EV_SYN: begin
            if (ev_r.event_code == SYN_CODE_REPORT) begin
              scale_y_nxt    = pend_y_vld_r && (abs_y_range_r != 16'd0);
              pend_x_vld_nxt = 1'b0;
              pend_y_vld_nxt = 1'b0;
              if (pend_x_vld_r && (abs_x_range_r != 16'd0)) begin
                state_nxt = ST_X_START;
              end else if (pend_y_vld_r && (abs_y_range_r != 16'd0)) begin
                state_nxt = ST_Y_START;
              end
            end
          end
          default: ;
        endcase
      end
      ST_X_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (div_rsp.done) begin
          pos_x_nxt = div_rsp.quotient;
          state_nxt = scale_y_r ? ST_Y_START : ST_DONE;
        end
      end
      ST_Y_START: begin
        div_req.start = 1'b1;
        div_req.value = pend_y_r;
        div_req.range = abs_y_range_r;
        div_req.bound = eff_y;
        state_nxt     = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_rsp.done) begin
          pos_y_nxt = div_rsp.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.cursor_x    = 16'(pos_x_r);
          out_data_nxt.cursor_y    = 16'(pos_y_r);
          out_data_nxt.button_mask = buttons_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // configuration write only while idle is the user's duty, unchecked; a bound write clamps the cursor
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ABS_X_RANGE: abs_x_range_nxt = cfg_wdata;
        CFG_ABS_Y_RANGE: abs_y_range_nxt = cfg_wdata;
        CFG_SCREEN_X_BOUND: begin
          bound_x_nxt = cfg_wdata;
          if (pos_x_r > cfg_eff) begin
            pos_x_nxt = cfg_eff;
          end
        end
        CFG_SCREEN_Y_BOUND: begin
          bound_y_nxt = cfg_wdata;
          if (pos_y_r > cfg_eff) begin
            pos_y_nxt = cfg_eff;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
